>>> rtl/core/assert_macros.svh
// Assertion macros used by the top RTL file of the normalizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rzn_pkg.sv
// Shared types and constants of the running z-score normalizer.
package rzn_pkg;

  localparam int unsigned MAX_DIM_DEF = 16;
  localparam int unsigned DIM_W       = 5;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned SCORE_W     = 18;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned CNT_W       = 32;

  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(16);

  // Tuple handed from the front to the back.
  typedef struct packed {
    logic err;
    logic bank;
  } job_t;

  // Buffer bank handed back by the back when a tuple is done.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
    logic                      run_end;
    logic                      length_error;
  } result_t;

  // Per-channel statistics word.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        sq;
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
  } stats_t;

  localparam stats_t STATS_RST = '{
    sum:  '0,
    sq:   '0,
    low:  32'sh7FFF_FFFF,
    high: 32'sh8000_0000
  };

  localparam int unsigned STATS_W = $bits(stats_t);
  localparam int unsigned RES_W   = $bits(result_t);
  localparam int unsigned JOB_W   = $bits(job_t);

endpackage

>>> rtl/core/rzn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rzn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rzn_fifo.sv
// Small register FIFO used for the tuple queue and the result queue.
module rzn_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/rzn_front.sv
// Element intake: buffers elements into a free bank and classifies each tuple.
module rzn_front #(
  parameter int unsigned MAX_DIM = 16,
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rzn_pkg::DIM_W-1:0]   dim_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [rzn_pkg::VAL_W-1:0]   sample_value_i,
  input  logic [rzn_pkg::TAG_W-1:0]   element_tag_i,
  input  logic                        tuple_end_i,
  output logic                        buf_we_o,
  output logic [IDX_W:0]              buf_waddr_o,
  output logic [rzn_pkg::VAL_W+rzn_pkg::TAG_W-1:0] buf_wdata_o,
  output logic                        job_push_o,
  input  logic                        job_full_i,
  output rzn_pkg::job_t               job_o,
  input  rzn_pkg::rel_t               rel_i
);
  import rzn_pkg::*;

  localparam int unsigned FW = $clog2(MAX_DIM + 2);
  localparam int unsigned CW = (FW > DIM_W) ? FW : DIM_W;

  logic [FW-1:0] fill_q;
  logic          bank_q;
  logic [1:0]    busy_q, busy_d;
  logic          accept;
  logic [FW-1:0] count;
  logic          err;

  assign full_o = job_full_i || busy_q[bank_q];
  assign accept = push_i && !full_o;

  // Saturate the element count one past the buffer depth.
  assign count = (fill_q <= FW'(MAX_DIM)) ? fill_q + 1'b1 : fill_q;
  assign err   = (dim_i == '0) || (CW'(dim_i) > CW'(MAX_DIM)) || (CW'(count) != CW'(dim_i));

  assign buf_we_o    = accept && (fill_q < FW'(MAX_DIM));
  assign buf_waddr_o = {bank_q, fill_q[IDX_W-1:0]};
  assign buf_wdata_o = {sample_value_i, element_tag_i};

  assign job_push_o = accept && tuple_end_i;
  assign job_o      = '{err: err, bank: bank_q};

  // Free a bank the back is done with; claim the bank of a good tuple.
  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept && tuple_end_i && !err) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        if (tuple_end_i) begin
          fill_q <= '0;
          // Hand a good tuple's bank to the back and switch to the other one.
          if (!err) begin
            bank_q <= ~bank_q;
          end
        end else begin
          fill_q <= count;
        end
      end
    end
  end

endmodule

>>> rtl/core/rzn_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module rzn_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rzn_pkg::SUM_W-1:0] dividend_i,
  input  logic [rzn_pkg::SUM_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rzn_pkg::SUM_W-1:0] quotient_o
);
  import rzn_pkg::*;

  localparam int unsigned KW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_q, div_q, rem_q;
  logic [KW-1:0]    cnt_q;
  logic             done_q;
  logic [SUM_W:0]   rem_sh;
  logic [SUM_W:0]   rem_sub;

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q <= dividend_i;
        div_q <= divisor_i;
        rem_q <= '0;
        cnt_q <= KW'(SUM_W);
      end else if (cnt_q != '0) begin
        if (!rem_sub[SUM_W]) begin
          rem_q <= rem_sub[SUM_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[SUM_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == KW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/core/rzn_back.sv
// Statistics engine: walks the channels of a tuple and produces the scores.
module rzn_back #(
  parameter int unsigned MAX_DIM = 16,
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [rzn_pkg::DIM_W-1:0]                dim_i,
  input  logic                                     job_empty_i,
  input  rzn_pkg::job_t                            job_i,
  output logic                                     job_pop_o,
  output logic [IDX_W:0]                           buf_raddr_o,
  input  logic [rzn_pkg::VAL_W+rzn_pkg::TAG_W-1:0] buf_rdata_i,
  output rzn_pkg::rel_t                            rel_o,
  output logic                                     res_push_o,
  input  logic                                     res_full_i,
  output rzn_pkg::result_t                         res_o
);
  import rzn_pkg::*;

  localparam int unsigned CW = (IDX_W + 1 > DIM_W) ? IDX_W + 1 : DIM_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ERR, ST_START, ST_READ, ST_LOAD, ST_MEAN_GO, ST_MEAN_WAIT,
    ST_DEV, ST_MUL, ST_SQ, ST_VAR_GO, ST_VAR_WAIT, ST_SQRT, ST_Z_GO,
    ST_Z_WAIT, ST_RANGE, ST_S_GO, ST_S_WAIT, ST_EMIT, ST_WB
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          n_q;
  logic [IDX_W-1:0]          ch_q;
  logic                      bank_q;
  logic [MAX_DIM-1:0]        vld_q;
  stats_t                    st_q;
  logic signed [VAL_W-1:0]   v_q, mean_q, z_q;
  logic [TAG_W-1:0]          tag_q;
  logic                      dev_neg_q;
  logic [VAL_W-1:0]          mag_q;
  logic [SUM_W-1:0]          prod_q;
  logic [SUM_W-1:0]          x_q, r_q, bit_q;
  logic signed [SCORE_W-1:0] s_q;
  logic                      div_start_q;
  logic [SUM_W-1:0]          div_a_q, div_b_q;
  logic                      job_pop_q, res_push_q;
  rel_t                      rel_q;
  result_t                   res_q;

  logic                      div_done;
  logic [SUM_W-1:0]          quo;
  logic [STATS_W-1:0]        st_rdata;
  stats_t                    st_rd;
  logic signed [VAL_W-1:0]   v_in;
  logic [SUM_W:0]            sum_ext, sq_ext, sq_root_t;
  logic [SUM_W-1:0]          sum_sat, sq_sat, sum_abs;
  logic [VAL_W:0]            dev, dev_mag;
  logic [VAL_W-1:0]          mean_c, z_c;
  logic [VAL_W:0]            num, den;
  logic                      last;

  rzn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  rzn_ram #(.WIDTH(STATS_W), .DEPTH(MAX_DIM)) u_stats (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WB),
    .waddr_i (ch_q),
    .wdata_i (st_q),
    .raddr_i (ch_q),
    .rdata_o (st_rdata)
  );

  assign buf_raddr_o = {bank_q, ch_q};
  assign last        = (CW'(ch_q) + CW'(1)) == CW'(dim_i);

  always_comb begin
    st_rd   = vld_q[ch_q] ? stats_t'(st_rdata) : STATS_RST;
    v_in    = buf_rdata_i[VAL_W+TAG_W-1:TAG_W];
    sum_ext = {st_rd.sum[SUM_W-1], st_rd.sum}
            + {{(SUM_W-VAL_W+1){v_in[VAL_W-1]}}, v_in};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
    sum_abs = st_q.sum[SUM_W-1] ? (~st_q.sum + 1'b1) : st_q.sum;

    // Clamp the truncated mean to 32 bits.
    if (st_q.sum[SUM_W-1]) begin
      mean_c = (quo > SUM_W'(64'h8000_0000)) ? 32'h8000_0000 : (~quo[VAL_W-1:0] + 1'b1);
    end else begin
      mean_c = (quo > SUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[VAL_W-1:0];
    end

    dev     = {v_q[VAL_W-1], v_q} - {mean_q[VAL_W-1], mean_q};
    dev_mag = dev[VAL_W] ? (~dev + 1'b1) : dev;

    sq_ext = {1'b0, st_q.sq} + (SUM_W+1)'(prod_q[SUM_W-1:16]);
    sq_sat = sq_ext[SUM_W] ? {SUM_W{1'b1}} : sq_ext[SUM_W-1:0];

    sq_root_t = {1'b0, r_q} + {1'b0, bit_q};

    if (dev_neg_q) begin
      z_c = (quo > SUM_W'(64'h8000_0000)) ? 32'h8000_0000 : (~quo[VAL_W-1:0] + 1'b1);
    end else begin
      z_c = (quo > SUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[VAL_W-1:0];
    end

    num = {z_q[VAL_W-1], z_q} - {st_q.low[VAL_W-1], st_q.low};
    den = {st_q.high[VAL_W-1], st_q.high} - {st_q.low[VAL_W-1], st_q.low};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      ch_q        <= '0;
      bank_q      <= 1'b0;
      vld_q       <= '0;
      div_start_q <= 1'b0;
      job_pop_q   <= 1'b0;
      res_push_q  <= 1'b0;
      rel_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      job_pop_q   <= 1'b0;
      res_push_q  <= 1'b0;
      rel_q.valid <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!job_empty_i && !job_pop_q) begin
            bank_q  <= job_i.bank;
            state_q <= job_i.err ? ST_ERR : ST_START;
          end
        end
        ST_ERR: begin
          if (!res_full_i) begin
            res_push_q <= 1'b1;
            res_q      <= '{tag: '0, score: '0, run_end: 1'b0, length_error: 1'b1};
            job_pop_q  <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        ST_START: begin
          n_q     <= (n_q == {CNT_W{1'b1}}) ? n_q : n_q + 1'b1;
          ch_q    <= '0;
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          v_q       <= v_in;
          tag_q     <= buf_rdata_i[TAG_W-1:0];
          st_q      <= '{sum: sum_sat, sq: st_rd.sq, low: st_rd.low, high: st_rd.high};
          state_q   <= (n_q <= CNT_W'(2)) ? ST_WB : ST_MEAN_GO;
        end
        ST_MEAN_GO: begin
          div_start_q <= 1'b1;
          div_a_q     <= sum_abs;
          div_b_q     <= SUM_W'(n_q);
          state_q     <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (div_done) begin
            mean_q  <= mean_c;
            state_q <= ST_DEV;
          end
        end
        ST_DEV: begin
          dev_neg_q <= dev[VAL_W];
          mag_q     <= dev_mag[VAL_W-1:0];
          state_q   <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= SUM_W'(mag_q) * SUM_W'(mag_q);
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          st_q.sq <= sq_sat;
          state_q <= ST_VAR_GO;
        end
        ST_VAR_GO: begin
          div_start_q <= 1'b1;
          div_a_q     <= st_q.sq;
          div_b_q     <= SUM_W'(n_q - 1'b1);
          state_q     <= ST_VAR_WAIT;
        end
        ST_VAR_WAIT: begin
          if (div_done) begin
            // Clamp the variance to 48 bits and scale it for the Q16.16 root.
            x_q     <= (|quo[SUM_W-1:48]) ? {{48{1'b1}}, 16'h0000} : {quo[47:0], 16'h0000};
            r_q     <= '0;
            bit_q   <= {2'b01, {(SUM_W-2){1'b0}}};
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (x_q >= sq_root_t[SUM_W-1:0]) begin
            x_q <= x_q - sq_root_t[SUM_W-1:0];
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            state_q <= ST_Z_GO;
          end
        end
        ST_Z_GO: begin
          // Zero standard deviation gives a zero z value.
          if (r_q[VAL_W-1:0] == '0) begin
            z_q     <= '0;
            state_q <= ST_RANGE;
          end else begin
            div_start_q <= 1'b1;
            div_a_q     <= {{(SUM_W-VAL_W-16){1'b0}}, mag_q, 16'h0000};
            div_b_q     <= {{(SUM_W-VAL_W){1'b0}}, r_q[VAL_W-1:0]};
            state_q     <= ST_Z_WAIT;
          end
        end
        ST_Z_WAIT: begin
          if (div_done) begin
            z_q     <= z_c;
            state_q <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          if (z_q > st_q.high) begin
            st_q.high <= z_q;
          end
          if (z_q < st_q.low) begin
            st_q.low <= z_q;
          end
          state_q <= (n_q > CNT_W'(3)) ? ST_S_GO : ST_WB;
        end
        ST_S_GO: begin
          // Flat range gives a zero score.
          if (st_q.high == st_q.low) begin
            s_q     <= '0;
            state_q <= ST_EMIT;
          end else begin
            div_start_q <= 1'b1;
            div_a_q     <= {{(SUM_W-VAL_W-18){1'b0}}, num, 17'h00000};
            div_b_q     <= {{(SUM_W-VAL_W-1){1'b0}}, den};
            state_q     <= ST_S_WAIT;
          end
        end
        ST_S_WAIT: begin
          if (div_done) begin
            s_q     <= $signed(quo[SCORE_W-1:0]) - SCORE_W'(65536);
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_full_i) begin
            res_push_q <= 1'b1;
            res_q      <= '{tag: tag_q, score: s_q, run_end: last, length_error: 1'b0};
            state_q    <= ST_WB;
          end
        end
        ST_WB: begin
          vld_q[ch_q] <= 1'b1;
          if (last) begin
            job_pop_q   <= 1'b1;
            rel_q.valid <= 1'b1;
            rel_q.bank  <= bank_q;
            state_q     <= ST_IDLE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= ST_READ;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign job_pop_o  = job_pop_q;
  assign rel_o      = rel_q;
  assign res_push_o = res_push_q;
  assign res_o      = res_q;

endmodule

>>> rtl/core/running_zscore_minmax_normalizer.sv
// Running z-score normalizer with min-max scaling. Elements of a tuple are
// pushed one per cycle while full is low (push/full) and buffered in one of
// two banks; the element with tuple_end set closes the tuple. Every tuple
// goes to a two-entry tuple queue and a good one claims its bank, so the
// next tuple can be loaded into the other bank while this one is worked.
// Each channel of a tuple is processed serially by one statistics engine
// that shares a single radix-2 divider (64 quotient steps) and a bit-serial
// square root. From the fourth tuple on a channel runs up to four divisions,
// the root and the load, multiply and write steps, and gives a score; in the
// first two tuples a channel is only loaded and written back, and in the
// third it runs up to three divisions and the root but gives no score.
// A tuple of the wrong length, or with a dimension of zero or above MAX_DIM,
// gives one result with length_error set. Results wait in a two-entry queue
// read with empty/pop; the engine stalls only while that queue is full.
// The dimension register is written through cfg_valid_i/cfg_data_i and may
// only change while no tuple is in flight; it resets to 16.
`include "assert_macros.svh"

module running_zscore_minmax_normalizer #(
  parameter int unsigned MAX_DIM = rzn_pkg::MAX_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rzn_pkg::DIM_W-1:0]         cfg_data_i,
  // element input
  input  logic                              push,
  output logic                              full,
  input  logic signed [rzn_pkg::VAL_W-1:0]  sample_value_i,
  input  logic [rzn_pkg::TAG_W-1:0]         element_tag_i,
  input  logic                              tuple_end_i,
  // result output
  output logic                              empty,
  input  logic                              pop,
  output logic [rzn_pkg::TAG_W-1:0]         tag_out_o,
  output logic signed [rzn_pkg::SCORE_W-1:0] scaled_score_o,
  output logic                              run_end_o,
  output logic                              length_error_o
);
  import rzn_pkg::*;

  localparam int unsigned IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned BUF_DEPTH  = 2 ** (IDX_W + 1);
  localparam int unsigned BUF_W      = VAL_W + TAG_W;

  logic [DIM_W-1:0] dim_q;

  logic             buf_we;
  logic [IDX_W:0]   buf_waddr, buf_raddr;
  logic [BUF_W-1:0] buf_wdata, buf_rdata;

  logic             job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0] job_raw;
  job_t             job_in;
  rel_t             rel;

  logic             res_push, res_full;
  result_t          res_in, res_out;
  logic [RES_W-1:0] res_raw;

  // Always take configuration writes; the front reads the dimension at tuple end, the back per channel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dim_q <= cfg_data_i;
    end
  end

  // Front: buffer elements and classify each tuple.
  rzn_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dim_i          (dim_q),
    .push_i         (push),
    .full_o         (full),
    .sample_value_i (sample_value_i),
    .element_tag_i  (element_tag_i),
    .tuple_end_i    (tuple_end_i),
    .buf_we_o       (buf_we),
    .buf_waddr_o    (buf_waddr),
    .buf_wdata_o    (buf_wdata),
    .job_push_o     (job_push),
    .job_full_i     (job_full),
    .job_o          (job_in),
    .rel_i          (rel)
  );

  // Two banks of element buffer, written by the front, read by the back.
  rzn_ram #(.WIDTH(BUF_W), .DEPTH(BUF_DEPTH)) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // Tuple queue between front and back.
  rzn_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (job_raw)
  );

  // Back: per-channel statistics and scoring.
  rzn_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dim_i       (dim_q),
    .job_empty_i (job_empty),
    .job_i       (job_t'(job_raw)),
    .job_pop_o   (job_pop),
    .buf_raddr_o (buf_raddr),
    .buf_rdata_i (buf_rdata),
    .rel_o       (rel),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (res_in)
  );

  // Result queue; its head drives the result ports.
  rzn_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_raw)
  );

  assign res_out        = result_t'(res_raw);
  assign tag_out_o      = res_out.tag;
  assign scaled_score_o = res_out.score;
  assign run_end_o      = res_out.run_end;
  assign length_error_o = res_out.length_error;

  // A shown score lies in [-1, 1].
  `ASSERT_IMPLIES(a_score_range, clk_i, rst_ni, !empty, (scaled_score_o >= -18'sd65536) && (scaled_score_o <= 18'sd65536), "score out of range")
  // An error result carries no tag, score or end mark.
  `ASSERT_IMPLIES(a_err_clean, clk_i, rst_ni, !empty && length_error_o, (tag_out_o == '0) && (scaled_score_o == '0) && !run_end_o, "error result not clean")
  // A bank is released only while its tuple still heads the queue.
  `ASSERT_IMPLIES(a_rel_job, clk_i, rst_ni, rel.valid, !job_empty && job_pop, "bank released without a tuple")

endmodule

>>> verif/running_zscore_minmax_normalizer_test.sv
// Testbench of the running z-score min-max normalizer: directed and random tuples.
`timescale 1ns / 1ps

module running_zscore_minmax_normalizer_test;
  import rzn_pkg::*;

  localparam int unsigned CHANNELS  = 16;
  // Settle time for the worst tuple of 16 channels, plus margin.
  localparam int unsigned SETTLE    = 5400;
  localparam int unsigned MAX_CYCLE = 2000000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [DIM_W-1:0]          cfg_data_i = '0;
  logic                      push = 1'b0;
  logic                      full;
  logic signed [VAL_W-1:0]   sample_value_i = '0;
  logic [TAG_W-1:0]          element_tag_i = '0;
  logic                      tuple_end_i = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [TAG_W-1:0]          tag_out_o;
  logic signed [SCORE_W-1:0] scaled_score_o;
  logic                      run_end_o;
  logic                      length_error_o;

  running_zscore_minmax_normalizer dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scoreboard state: expected scores, oldest first.
  result_t score_queue[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      idling_on = 1'b1;

  // Own copy of the block's state.
  logic [DIM_W-1:0]        tuple_dim;
  logic signed [31:0]      held_value[CHANNELS];
  logic [31:0]             held_tag[CHANNELS];
  int unsigned             fill_count;
  logic [31:0]             tuples_seen;
  longint                  sum_acc[CHANNELS];
  longint unsigned         sqdev_acc[CHANNELS];
  logic signed [31:0]      z_low[CHANNELS];
  logic signed [31:0]      z_high[CHANNELS];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Advance the statistics on one accepted element; queue the results it causes.
  task automatic predict_scores(logic signed [31:0] v, logic [31:0] tag, logic last);
    int unsigned     cnt;
    longint          mean, dev, z, s, sum_new;
    longint unsigned mag, sq, var_q, sd, q, num, den;
    result_t         r;
    if (fill_count < CHANNELS) begin
      held_value[fill_count] = v;
      held_tag[fill_count] = tag;
    end
    if (fill_count <= CHANNELS) fill_count++;
    if (!last) return;
    cnt = fill_count;
    fill_count = 0;
    if (tuple_dim == 0 || tuple_dim > CHANNELS || cnt != tuple_dim) begin
      r = '0;
      r.length_error = 1'b1;
      score_queue.push_back(r);
      return;
    end
    if (tuples_seen != 32'hFFFF_FFFF) tuples_seen++;
    for (int i = 0; i < tuple_dim; i++) begin
      sum_new = sum_acc[i] + longint'(held_value[i]);
      if (held_value[i] > 0 && sum_new < sum_acc[i]) sum_new = 64'sh7FFF_FFFF_FFFF_FFFF;
      if (held_value[i] < 0 && sum_new > sum_acc[i]) sum_new = 64'sh8000_0000_0000_0000;
      sum_acc[i] = sum_new;
      if (tuples_seen <= 2) continue;
      mean = sum_acc[i] / longint'(tuples_seen);
      if (mean > 64'sd2147483647) mean = 64'sd2147483647;
      if (mean < -64'sd2147483648) mean = -64'sd2147483648;
      dev = longint'(held_value[i]) - mean;
      mag = (dev < 0) ? -dev : dev;
      sq = (mag * mag) >> 16;
      if (sqdev_acc[i] > 64'hFFFF_FFFF_FFFF_FFFF - sq) sqdev_acc[i] = 64'hFFFF_FFFF_FFFF_FFFF;
      else sqdev_acc[i] += sq;
      var_q = sqdev_acc[i] / longint'(tuples_seen - 1);
      if (var_q > (64'd1 << 48) - 1) var_q = (64'd1 << 48) - 1;
      sd = int_sqrt(var_q << 16);
      if (sd == 0) begin
        z = 0;   // zero standard deviation
      end else begin
        q = (mag << 16) / sd;
        if (dev < 0) begin
          if (q > 64'd2147483648) q = 64'd2147483648;
          z = -longint'(q);
        end else begin
          if (q > 64'd2147483647) q = 64'd2147483647;
          z = longint'(q);
        end
      end
      if (z > z_high[i]) z_high[i] = z[31:0];
      if (z < z_low[i]) z_low[i] = z[31:0];
      if (tuples_seen > 3) begin
        if (z_high[i] == z_low[i]) begin
          s = 0;   // flat range
        end else begin
          num = z - longint'(z_low[i]);
          den = longint'(z_high[i]) - longint'(z_low[i]);
          s = longint'((num << 17) / den) - 65536;
        end
        r.tag = held_tag[i];
        r.score = s[SCORE_W-1:0];
        r.run_end = (i == tuple_dim - 1);
        r.length_error = 1'b0;
        score_queue.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && !empty && pop) begin
      if (score_queue.size() == 0) begin
        report_mismatch("unexpected result, tag", tag_out_o, 0);
      end else begin
        want = score_queue.pop_front();
        if (tag_out_o !== want.tag) report_mismatch("tag_out", tag_out_o, want.tag);
        if (scaled_score_o !== want.score)
          report_mismatch("scaled_score", scaled_score_o, want.score);
        if (run_end_o !== want.run_end) report_mismatch("run_end", run_end_o, want.run_end);
        if (length_error_o !== want.length_error)
          report_mismatch("length_error", length_error_o, want.length_error);
      end
    end
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("running_zscore_minmax_normalizer_test: done, errors");
      $finish;
    end
  end

  // Receiver: stall in random bursts while idling is on.
  int pop_hold = 0;
  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop = 1'b0;
      pop_hold--;
    end else if (idling_on && $urandom_range(0, 15) == 0) begin
      pop = 1'b0;
      pop_hold = $urandom_range(0, 11);
    end else begin
      pop = 1'b1;
    end
  end

  // Push one element and hold it until the transfer.
  task automatic send_element(logic signed [31:0] v, logic [31:0] tag, logic last);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    sample_value_i = v;
    element_tag_i = tag;
    tuple_end_i = last;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    predict_scores(v, tag, last);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic send_tuple(int len, int mode);
    logic signed [31:0] v;
    for (int k = 0; k < len; k++) begin
      case (mode)
        0: v = $urandom;
        1: v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        default: v = 32'sh0001_8000;
      endcase
      send_element(v, $urandom, k == len - 1);
    end
  endtask

  // Hold until every expected result is out and the engine has settled.
  task automatic drain_block();
    push = 1'b0;
    while (score_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_dimension(logic [DIM_W-1:0] d);
    drain_block();
    cfg_data_i = d;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tuple_dim = d;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Default dimension: a short tuple is a length mismatch.
  task automatic test_default_dimension();
    send_tuple(3, 0);
  endtask

  // Constant channels (zero deviation, flat range), then field extremes, a one-element mismatch and a random tuple.
  task automatic test_directed_extremes();
    write_dimension(2);
    for (int t = 0; t < 4; t++) send_tuple(2, 2);
    send_element(32'sh8000_0000, 32'h0000_0000, 1'b0);
    send_element(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_element(32'sh7FFF_FFFF, 32'hAAAA_5555, 1'b0);
    send_element(32'sh8000_0000, 32'h5555_AAAA, 1'b1);
    send_element(32'sh0000_0000, 32'h1234_5678, 1'b1);   // one element: mismatch
    send_tuple(2, 1);
  endtask

  // Random tuples at one dimension: mostly right length where the dimension is valid, some wrong or overlong.
  task automatic test_random_phase(logic [DIM_W-1:0] d, int items);
    int sent = 0;
    int len;
    write_dimension(d);
    while (sent < items) begin
      if (d >= 1 && d <= CHANNELS && $urandom_range(0, 9) != 0) len = d;
      else len = $urandom_range(1, CHANNELS + 3);
      send_tuple(len, $urandom_range(0, 1));
      sent += len;
    end
  endtask

  task automatic test_drain_pause();
    send_tuple(tuple_dim, 1);
    drain_block();
    send_tuple(tuple_dim, 0);
  endtask

  initial begin
    tuple_dim = DIM_RST;
    fill_count = 0;
    tuples_seen = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sum_acc[i] = 0;
      sqdev_acc[i] = 0;
      z_low[i] = 32'sh7FFF_FFFF;
      z_high[i] = 32'sh8000_0000;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_dimension();
    test_directed_extremes();
    test_random_phase(5'd1, 60);
    test_random_phase(5'd3, 70);
    test_random_phase(5'd16, 80);
    test_random_phase(5'd0, 20);
    test_random_phase(5'd31, 20);
    test_random_phase(5'($urandom_range(1, 16)), 60);
    test_drain_pause();
    idling_on = 1'b0;
    test_random_phase(5'd4, 60);

    drain_block();
    if (error_count == 0) begin
      $display("running_zscore_minmax_normalizer_test: done, clean");
    end else begin
      $display("running_zscore_minmax_normalizer_test: done, errors");
    end
    $finish;
  end

endmodule

>>> running_zscore_minmax_normalizer.f
+incdir+rtl/core
rtl/core/rzn_pkg.sv
rtl/core/rzn_ram.sv
rtl/core/rzn_fifo.sv
rtl/core/rzn_front.sv
rtl/core/rzn_div.sv
rtl/core/rzn_back.sv
rtl/core/running_zscore_minmax_normalizer.sv
verif/running_zscore_minmax_normalizer_test.sv
